// ===== rtl/core/gbip_pkg.sv =====
// gbip_pkg: shared constants, word types and control structs for the
// group-by-index partition block; no dependencies
package gbip_pkg;

    localparam int DEPTH       = 32;
    localparam int GROUPS      = 32;
    localparam int DATA_WIDTH  = 32;
    localparam int MAX_RESULTS = 64;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int GIDX_W = $clog2(GROUPS);
    localparam int GCNT_W = $clog2(GROUPS + 1);
    localparam int SUM_W  = CNT_W + 8;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_INDEX = 2'd1;
    localparam logic [1:0] ERR_CAP   = 2'd2;

    localparam logic signed [6:0] IDX_DROP = -7'sd1;

    typedef struct packed {
        logic signed [6:0] group_index;
        logic [31:0]       cell_value;
        logic              last_item;
        logic [5:0]        length_floor;
    } item_t;

    typedef struct packed {
        logic [4:0]  group_number;
        logic [31:0] cell_value_res;
        logic        group_empty;
        logic        last_of_group;
        logic [5:0]  group_count;
        logic [1:0]  error_code;
        logic        last_result;
    } res_t;

    typedef struct packed {
        logic [GIDX_W-1:0]     idx;
        logic [DATA_WIDTH-1:0] val;
    } entry_t;

    typedef enum logic [2:0] {
        PUSH_NONE,
        PUSH_SINGLE,
        PUSH_EMPTY,
        PUSH_MID,
        PUSH_LAST
    } push_t;

    typedef struct packed {
        logic  load;
        logic  fin;
        logic  clear;
        logic  grp_start;
        logic  grp_next;
        logic  scan_start;
        logic  rd;
        logic  take;
        push_t push;
    } cmd_t;

    typedef struct packed {
        logic err_nz;
        logic count_zero;
        logic seen;
        logic scan_done;
        logic match;
        logic g_last;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/core/gbip_dp.sv =====
// gbip_dp: element memory, group bookkeeping, scan counters and output register
// depends on gbip_pkg; driven by gbip_ctrl commands
module gbip_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  gbip_pkg::item_t item,
    input  gbip_pkg::cmd_t  cmd,
    output gbip_pkg::sts_t  sts,
    output gbip_pkg::res_t  res,
    output logic           res_valid,
    input  logic           res_stall
);

    gbip_pkg::entry_t mem [gbip_pkg::DEPTH];

    logic [1:0]                  err_reg, err_next;
    logic [gbip_pkg::CNT_W-1:0]  elem_reg;
    logic [5:0]                  hi_reg;
    logic [gbip_pkg::GCNT_W-1:0] nonempty_reg;
    logic [gbip_pkg::GROUPS-1:0] seen_reg;
    logic                        res_valid_reg;

    logic [5:0]                      floor_reg;
    logic [5:0]                      count_reg;
    logic [gbip_pkg::GIDX_W-1:0]     g_reg;
    logic [gbip_pkg::CNT_W-1:0]      i_reg;
    logic [gbip_pkg::DATA_WIDTH-1:0] pend_reg;
    gbip_pkg::entry_t                rd_reg;
    gbip_pkg::res_t                  res_reg, res_next;

    logic                        idx_neg, idx_bad, idx_over, full, store, out_free;
    logic [5:0]                  idx_u, idx_p1, cnt_c;
    logic [gbip_pkg::SUM_W-1:0]  sum_c;

    assign idx_neg  = item.group_index[6];
    assign idx_bad  = item.group_index < gbip_pkg::IDX_DROP;
    assign idx_u    = item.group_index[5:0];
    assign idx_p1   = idx_u + 6'd1;
    assign idx_over = idx_u >= 6'(gbip_pkg::GROUPS);
    assign full     = elem_reg >= gbip_pkg::CNT_W'(gbip_pkg::DEPTH);
    assign store    = cmd.load && !idx_neg && !idx_over && !full
                      && (err_reg == gbip_pkg::ERR_NONE);

    assign cnt_c = (floor_reg > hi_reg) ? floor_reg : hi_reg;
    assign sum_c = gbip_pkg::SUM_W'(elem_reg) + gbip_pkg::SUM_W'(cnt_c)
                   - gbip_pkg::SUM_W'(nonempty_reg);

    assign out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        err_next = err_reg;
        if (cmd.load)
        begin
            if (idx_bad)
                err_next = gbip_pkg::ERR_INDEX;
            else if (!idx_neg && (idx_over || full) && err_reg == gbip_pkg::ERR_NONE)
                err_next = gbip_pkg::ERR_CAP;
        end
        else if (cmd.fin)
        begin
            if (err_reg == gbip_pkg::ERR_NONE
                && (floor_reg > 6'(gbip_pkg::GROUPS)
                    || sum_c > gbip_pkg::SUM_W'(gbip_pkg::MAX_RESULTS)))
                err_next = gbip_pkg::ERR_CAP;
        end
    end

    always_comb
    begin
        res_next = '0;
        res_next.group_number  = 5'(g_reg);
        res_next.group_count   = count_reg;
        res_next.error_code    = gbip_pkg::ERR_NONE;
        case (cmd.push)
            gbip_pkg::PUSH_SINGLE:
            begin
                res_next.group_number = '0;
                res_next.group_count  = '0;
                res_next.error_code   = err_reg;
                res_next.last_result  = 1'b1;
            end
            gbip_pkg::PUSH_EMPTY:
            begin
                res_next.group_empty   = 1'b1;
                res_next.last_of_group = 1'b1;
                res_next.last_result   = sts.g_last;
            end
            gbip_pkg::PUSH_MID:
            begin
                res_next.cell_value_res = 32'(pend_reg);
            end
            gbip_pkg::PUSH_LAST:
            begin
                res_next.cell_value_res = 32'(pend_reg);
                res_next.last_of_group  = 1'b1;
                res_next.last_result    = sts.g_last;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg       <= gbip_pkg::ERR_NONE;
            elem_reg      <= '0;
            hi_reg        <= '0;
            nonempty_reg  <= '0;
            seen_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                err_reg      <= gbip_pkg::ERR_NONE;
                elem_reg     <= '0;
                hi_reg       <= '0;
                nonempty_reg <= '0;
                seen_reg     <= '0;
            end
            else
            begin
                err_reg <= err_next;
                if (store)
                begin
                    elem_reg <= elem_reg + gbip_pkg::CNT_W'(1);
                    seen_reg[idx_u[gbip_pkg::GIDX_W-1:0]] <= 1'b1;
                    if (!seen_reg[idx_u[gbip_pkg::GIDX_W-1:0]])
                        nonempty_reg <= nonempty_reg + gbip_pkg::GCNT_W'(1);
                    if (idx_p1 > hi_reg)
                        hi_reg <= idx_p1;
                end
            end
            if (cmd.push != gbip_pkg::PUSH_NONE)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
            mem[elem_reg[gbip_pkg::ADDR_W-1:0]] <= '{idx: idx_u[gbip_pkg::GIDX_W-1:0],
                                                    val: item.cell_value[gbip_pkg::DATA_WIDTH-1:0]};
        if (cmd.rd)
            rd_reg <= mem[i_reg[gbip_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            floor_reg <= item.length_floor;
        if (cmd.fin)
            count_reg <= cnt_c;
        if (cmd.grp_start)
            g_reg <= '0;
        else if (cmd.grp_next)
            g_reg <= g_reg + gbip_pkg::GIDX_W'(1);
        if (cmd.scan_start)
            i_reg <= '0;
        else if (cmd.rd)
            i_reg <= i_reg + gbip_pkg::CNT_W'(1);
        if (cmd.take)
            pend_reg <= rd_reg.val;
        if (cmd.push != gbip_pkg::PUSH_NONE)
            res_reg <= res_next;
    end

    assign sts.err_nz     = err_reg != gbip_pkg::ERR_NONE;
    assign sts.count_zero = count_reg == 6'd0;
    assign sts.seen       = seen_reg[g_reg];
    assign sts.scan_done  = i_reg == elem_reg;
    assign sts.match      = rd_reg.idx == g_reg;
    assign sts.g_last     = ({1'b0, g_reg} + 6'd1) == count_reg;
    assign sts.out_free   = out_free;

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

// ===== rtl/core/gbip_ctrl.sv =====
// gbip_ctrl: sequencer for load, final check and group-by-group emission
// depends on gbip_pkg; commands gbip_dp
module gbip_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  logic           last_item,
    output logic           item_stall,
    input  gbip_pkg::sts_t  sts,
    output gbip_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_FIN,
        S_DEC,
        S_GRP,
        S_SCAN,
        S_CMP,
        S_TAIL
    } state_t;

    state_t state_reg, state_next;

    // pending match held in the datapath for the current group
    logic cmd_pend_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.push   = gbip_pkg::PUSH_NONE;
        case (state_reg)
            S_LOAD:
            begin
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    if (last_item)
                        state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (sts.err_nz || sts.count_zero)
                begin
                    if (sts.out_free)
                    begin
                        cmd.push   = gbip_pkg::PUSH_SINGLE;
                        cmd.clear  = 1'b1;
                        state_next = S_LOAD;
                    end
                end
                else
                begin
                    cmd.grp_start = 1'b1;
                    state_next    = S_GRP;
                end
            end
            S_GRP:
            begin
                if (sts.seen)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (sts.out_free)
                begin
                    cmd.push = gbip_pkg::PUSH_EMPTY;
                    if (sts.g_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                        cmd.grp_next = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                    state_next = S_TAIL;
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (!sts.match)
                    state_next = S_SCAN;
                else if (!cmd_pend_reg)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_SCAN;
                end
                else if (sts.out_free)
                begin
                    cmd.push   = gbip_pkg::PUSH_MID;
                    cmd.take   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_TAIL:
            begin
                if (sts.out_free)
                begin
                    cmd.push = gbip_pkg::PUSH_LAST;
                    if (sts.g_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cmd.grp_next = 1'b1;
                        state_next   = S_GRP;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            cmd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.scan_start)
                cmd_pend_reg <= 1'b0;
            else if (cmd.take)
                cmd_pend_reg <= 1'b1;
        end
    end

    assign item_stall = state_reg != S_LOAD;

endmodule

// ===== rtl/core/group_by_index_partition_top.sv =====
// group_by_index_partition_top: loads one word per cycle while the list is open
// after the last word: a final check, then a lone word on error or zero groups, else
// a word per empty group and per element; each filled group rescans the element memory
// results leave through an output register; loading is stalled during emission
// asynchronous active-low reset clears the load counts, group marks and output valid
// depends on gbip_pkg, gbip_ctrl, gbip_dp
module group_by_index_partition_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  gbip_pkg::item_t item,
    output logic           res_valid,
    input  logic           res_stall,
    output gbip_pkg::res_t  res
);

    gbip_pkg::cmd_t cmd;
    gbip_pkg::sts_t sts;

    gbip_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .last_item  (item.last_item),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    gbip_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .sts       (sts),
        .res       (res),
        .res_valid (res_valid),
        .res_stall (res_stall)
    );

endmodule

// ===== rtl/core/gbip_checker.sv =====
// gbip_checker: port-level assertions for the partition block
// depends on gbip_pkg; bound to group_by_index_partition_top
module gbip_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           item_stall,
    input logic           res_valid,
    input logic           res_stall,
    input gbip_pkg::res_t  res
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result word changed");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.error_code != gbip_pkg::ERR_NONE |->
            res.last_result && res.group_count == 6'd0)
        else $error("error word not a lone final word");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.group_empty |-> res.last_of_group)
        else $error("empty marker not closing its group");

    a_final_group: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last_result && res.error_code == gbip_pkg::ERR_NONE
            && res.group_count != 6'd0 |->
            res.last_of_group && ({1'b0, res.group_number} + 6'd1) == res.group_count)
        else $error("final word not closing the last group");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.last_result |-> item_stall)
        else $error("input open while an answer is still in progress");

endmodule

bind group_by_index_partition_top gbip_checker u_gbip_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_stall (item_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
);

// ===== tb/sv/tb_group_by_index_partition_top.sv =====
// testbench for group_by_index_partition_top: directed and random lists of
// index/value words, results checked against an in-bench partition predictor
// depends on gbip_pkg and group_by_index_partition_top
module tb_group_by_index_partition_top;

    logic            clk;
    logic            rst_n;
    logic            item_valid;
    logic            item_stall;
    gbip_pkg::item_t item;
    logic            res_valid;
    logic            res_stall;
    gbip_pkg::res_t  res;

    gbip_pkg::res_t expected_words[$];
    int             fail_count;
    bit             quiet_phase;

    logic [4:0]  list_index [gbip_pkg::DEPTH];
    logic [31:0] list_value [gbip_pkg::DEPTH];
    int          bucket_len [gbip_pkg::GROUPS];
    int          kept_count;
    int          top_index;
    logic [1:0]  held_error;

    group_by_index_partition_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic clear_partition();
        kept_count = 0;
        top_index  = -1;
        held_error = gbip_pkg::ERR_NONE;
        for (int g = 0; g < gbip_pkg::GROUPS; g++)
        begin
            bucket_len[g] = 0;
        end
    endtask

    function automatic gbip_pkg::res_t make_word(int grp, logic [31:0] val, bit empty,
                                                 bit lastg, int cnt, logic [1:0] err,
                                                 bit lastr);
        gbip_pkg::res_t r;
        r.group_number   = grp[4:0];
        r.cell_value_res = val;
        r.group_empty    = empty;
        r.last_of_group  = lastg;
        r.group_count    = cnt[5:0];
        r.error_code     = err;
        r.last_result    = lastr;
        return r;
    endfunction

    task automatic predict_partition(gbip_pkg::item_t it);
        int             idx;
        int             cnt;
        int             empties;
        int             seen;
        int             n;
        gbip_pkg::res_t w;
        idx = int'(it.group_index);
        if (idx < -1)
        begin
            held_error = gbip_pkg::ERR_INDEX;
        end
        else if (idx >= 0)
        begin
            if (idx >= gbip_pkg::GROUPS || kept_count >= gbip_pkg::DEPTH)
            begin
                if (held_error == gbip_pkg::ERR_NONE) held_error = gbip_pkg::ERR_CAP;
            end
            else if (held_error == gbip_pkg::ERR_NONE)
            begin
                list_index[kept_count] = idx[4:0];
                list_value[kept_count] = it.cell_value;
                kept_count++;
                bucket_len[idx]++;
                if (idx > top_index) top_index = idx;
            end
        end
        if (!it.last_item) return;
        if (it.length_floor > gbip_pkg::GROUPS && held_error == gbip_pkg::ERR_NONE)
            held_error = gbip_pkg::ERR_CAP;
        cnt = top_index + 1;
        if (int'(it.length_floor) > cnt) cnt = it.length_floor;
        if (held_error == gbip_pkg::ERR_NONE)
        begin
            empties = 0;
            for (int g = 0; g < cnt && g < gbip_pkg::GROUPS; g++)
            begin
                if (bucket_len[g] == 0) empties++;
            end
            if (kept_count + empties > gbip_pkg::MAX_RESULTS) held_error = gbip_pkg::ERR_CAP;
        end
        if (held_error != gbip_pkg::ERR_NONE)
        begin
            expected_words.push_back(make_word(0, 0, 0, 0, 0, held_error, 1));
        end
        else if (cnt == 0)
        begin
            expected_words.push_back(make_word(0, 0, 0, 0, 0, gbip_pkg::ERR_NONE, 1));
        end
        else
        begin
            n = 0;
            for (int g = 0; g < cnt && g < gbip_pkg::GROUPS; g++)
            begin
                if (bucket_len[g] == 0)
                begin
                    w = make_word(g, 0, 1, 1, cnt, gbip_pkg::ERR_NONE, 0);
                    w.last_result = (g == cnt - 1);
                    expected_words.push_back(w);
                    continue;
                end
                seen = 0;
                for (int i = 0; i < kept_count; i++)
                begin
                    if (list_index[i] != g) continue;
                    seen++;
                    w = make_word(g, list_value[i], 0, seen == bucket_len[g], cnt,
                                  gbip_pkg::ERR_NONE,
                                  (g == cnt - 1) && (seen == bucket_len[g]));
                    expected_words.push_back(w);
                end
            end
        end
        clear_partition();
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        gbip_pkg::res_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch("unexpected word", 1, 0);
            end
            else
            begin
                e = expected_words.pop_front();
                if (res.error_code != e.error_code)
                    report_mismatch("error_code", res.error_code, e.error_code);
                if (res.last_result != e.last_result)
                    report_mismatch("last_result", res.last_result, e.last_result);
                if (res.group_count != e.group_count)
                    report_mismatch("group_count", res.group_count, e.group_count);
                if (res.group_number != e.group_number)
                    report_mismatch("group_number", res.group_number, e.group_number);
                if (res.group_empty != e.group_empty)
                    report_mismatch("group_empty", res.group_empty, e.group_empty);
                if (res.last_of_group != e.last_of_group)
                    report_mismatch("last_of_group", res.last_of_group, e.last_of_group);
                if (!e.group_empty && res.cell_value_res != e.cell_value_res)
                    report_mismatch("cell_value_res", res.cell_value_res, e.cell_value_res);
            end
        end
    end

    // receiver stall bursts
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet_phase && $urandom_range(0, 9) == 0)
            begin
                res_stall = 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                res_stall = 1'b0;
            end
        end
    end

    task automatic send_word(int idx, logic [31:0] val, bit lastw, int flr);
        gbip_pkg::item_t it;
        it.group_index  = idx[6:0];
        it.cell_value   = val;
        it.last_item    = lastw;
        it.length_floor = flr[5:0];
        if (!quiet_phase && $urandom_range(0, 7) == 0)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        item       = it;
        item_valid = 1'b1;
        do @(posedge clk); while (item_stall);
        predict_partition(it);
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    task automatic random_list(int len, int span, int pct_bad);
        int idx;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < pct_bad)
                idx = $urandom_range(0, 127) - 64;
            else if ($urandom_range(0, 9) == 0)
                idx = -1;
            else
                idx = $urandom_range(0, span - 1);
            send_word(idx, $urandom, i == len - 1,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : 0);
        end
    endtask

    task automatic test_directed();
        send_word(-1, 32'h0, 1, 0);
        send_word(0, 32'hFFFF_FFFF, 1, 0);
        send_word(31, 32'h1234_5678, 1, 0);
        send_word(3, 32'hA, 0, 0);
        send_word(1, 32'hB, 0, 0);
        send_word(3, 32'hC, 0, 0);
        send_word(-1, 32'hD, 1, 5);
        send_word(2, 32'h5, 1, 32);
        send_word(1, 32'h6, 1, 33);
        send_word(32, 32'h7, 1, 0);
        send_word(63, 32'h8, 1, 63);
        send_word(-2, 32'h9, 0, 0);
        send_word(40, 32'h9, 1, 0);
        send_word(-64, 32'h1, 1, 0);
        send_word(-1, 32'h2, 1, 1);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < 33; i++)
        begin
            send_word(i % 4, $urandom, i == 32, 0);
        end
        // many stored values plus many empty groups
        for (int i = 0; i < 32; i++)
        begin
            send_word(0, $urandom, i == 31, 32);
        end
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 125)
        begin
            int len;
            len = $urandom_range(1, 12);
            random_list(len, $urandom_range(1, 32), ($urandom_range(0, 4) == 0) ? 20 : 0);
            sent += len;
        end
    endtask

    task automatic test_no_idle();
        quiet_phase = 1'b1;
        random_list(20, 8, 0);
        random_list(6, 32, 0);
    endtask

    initial
    begin
        fail_count  = 0;
        quiet_phase = 1'b0;
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        clear_partition();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_overflow();
        test_random();
        test_no_idle();
        wait (expected_words.size() == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
